>>> hdl/x86_decimal_adjust_unit_macros.svh
// Assertion macros shared by the decimal adjust unit.
`ifndef X86_DECIMAL_ADJUST_UNIT_MACROS_SVH
`define X86_DECIMAL_ADJUST_UNIT_MACROS_SVH

// Same-cycle implication, checked on the rising clock edge outside reset.
`define DAU_ASSERT_IMPL(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |-> (rhs)) \
    else $error("dau: implication failed");

// Next-cycle implication, checked on the rising clock edge outside reset.
`define DAU_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |=> (rhs)) \
    else $error("dau: next-cycle implication failed");

`endif

>>> hdl/dau_pkg.sv
// Types, constants and helper functions of the decimal adjust unit.
package dau_pkg;

  typedef enum logic [2:0] {
    ACT_AAA = 3'd0,
    ACT_AAS = 3'd1,
    ACT_AAM = 3'd2,
    ACT_AAD = 3'd3,
    ACT_DAA = 3'd4,
    ACT_DAS = 3'd5
  } dau_action_e;

  localparam int unsigned ByteW = 8;
  // One restoring division step per cell, one cell per dividend bit.
  localparam int unsigned DivSteps = ByteW;

  localparam logic [3:0] NibbleMax = 4'd9;
  localparam logic [7:0] LowAdj    = 8'h06;
  localparam logic [7:0] HighAdj   = 8'h60;
  localparam logic [7:0] BcdMax    = 8'h99;

  typedef struct packed {
    logic [2:0]       action;
    logic [ByteW-1:0] al_in;
    logic [ByteW-1:0] ah_in;
    logic [ByteW-1:0] imm;
    logic             af_in;
    logic             cf_in;
    logic             of_in;
    logic [2:0]       zsp_in;
  } dau_req_t;

  typedef struct packed {
    logic [ByteW-1:0] al_out;
    logic [ByteW-1:0] ah_out;
    logic             af_out;
    logic             cf_out;
    logic             of_out;
    logic             zf_out;
    logic             sf_out;
    logic             pf_out;
    logic             status;
  } dau_res_t;

  // One slot of the division chain: the result so far plus the divider state.
  typedef struct packed {
    logic             valid;
    logic             do_div;
    logic [ByteW-1:0] div;
    logic [ByteW-1:0] rem;
    logic [ByteW-1:0] aq;
    dau_res_t         res;
  } dau_lane_t;

  // Returns {PF, SF, ZF} for a new AL.
  function automatic logic [2:0] dau_zsp(logic [ByteW-1:0] al);
    dau_zsp = {~^al, al[ByteW-1], (al == '0)};
  endfunction

endpackage

>>> hdl/dau_adjust.sv
// Entry logic: executes the adjust instructions and primes the division chain.
module dau_adjust (
  input  dau_pkg::dau_req_t  req_i,
  input  logic               valid_i,
  output dau_pkg::dau_lane_t lane_o
);
  import dau_pkg::*;

  logic             lo_fix;
  logic             hi_fix;
  logic [15:0]      prod;
  logic [ByteW-1:0] al_tmp;
  dau_res_t         res;

  assign lo_fix = (req_i.al_in[3:0] > NibbleMax) || req_i.af_in;
  assign hi_fix = (req_i.al_in > BcdMax) || req_i.cf_in;
  assign prod   = 16'(req_i.ah_in) * 16'(req_i.imm);

  always_comb begin
    res.al_out = req_i.al_in;
    res.ah_out = req_i.ah_in;
    res.af_out = req_i.af_in;
    res.cf_out = req_i.cf_in;
    res.of_out = req_i.of_in;
    res.zf_out = req_i.zsp_in[0];
    res.sf_out = req_i.zsp_in[1];
    res.pf_out = req_i.zsp_in[2];
    res.status = 1'b0;
    al_tmp     = req_i.al_in;
    case (req_i.action)
      ACT_AAA, ACT_AAS: begin
        if (lo_fix) begin
          if (req_i.action == ACT_AAA) begin
            al_tmp     = req_i.al_in + LowAdj;
            res.ah_out = req_i.ah_in + 8'd1;
          end else begin
            al_tmp     = req_i.al_in - LowAdj;
            res.ah_out = req_i.ah_in - 8'd1;
          end
        end
        res.af_out = lo_fix;
        res.cf_out = lo_fix;
        res.al_out = {4'h0, al_tmp[3:0]};
        {res.pf_out, res.sf_out, res.zf_out} = dau_zsp({4'h0, al_tmp[3:0]});
      end
      ACT_AAM: begin
        // A zero base only sets status; otherwise the chain fills in AL and AH.
        res.status = (req_i.imm == '0);
      end
      ACT_AAD: begin
        al_tmp     = req_i.al_in + prod[ByteW-1:0];
        res.al_out = al_tmp;
        res.ah_out = '0;
        res.of_out = 1'b0;
        res.cf_out = 1'b0;
        {res.pf_out, res.sf_out, res.zf_out} = dau_zsp(al_tmp);
      end
      ACT_DAA, ACT_DAS: begin
        if (lo_fix) begin
          al_tmp = (req_i.action == ACT_DAA) ? al_tmp + LowAdj : al_tmp - LowAdj;
        end
        // The high digit decision looks at the original AL and CF.
        if (hi_fix) begin
          al_tmp = (req_i.action == ACT_DAA) ? al_tmp + HighAdj : al_tmp - HighAdj;
        end
        res.af_out = lo_fix;
        res.cf_out = hi_fix;
        res.al_out = al_tmp;
        {res.pf_out, res.sf_out, res.zf_out} = dau_zsp(al_tmp);
      end
      default: begin
      end
    endcase
  end

  assign lane_o.valid  = valid_i;
  assign lane_o.do_div = (req_i.action == ACT_AAM) && (req_i.imm != '0);
  assign lane_o.div    = req_i.imm;
  assign lane_o.rem    = '0;
  assign lane_o.aq     = req_i.al_in;
  assign lane_o.res    = res;

endmodule

>>> hdl/dau_div_cell.sv
// One cell of the division chain: a single restoring step, registered.
module dau_div_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  dau_pkg::dau_lane_t lane_i,
  output dau_pkg::dau_lane_t lane_o
);
  import dau_pkg::*;

  logic             valid_q;
  dau_lane_t        lane_d;
  dau_lane_t        lane_q;
  logic [ByteW+1:0] diff;

  // The shifted partial remainder is one bit wider than a byte; a clear top bit
  // of the difference means the divisor fits.
  assign diff = {1'b0, lane_i.rem, lane_i.aq[ByteW-1]} - {2'b00, lane_i.div};

  always_comb begin
    lane_d = lane_i;
    if (!diff[ByteW+1]) begin
      lane_d.rem = diff[ByteW-1:0];
      lane_d.aq  = {lane_i.aq[ByteW-2:0], 1'b1};
    end else begin
      lane_d.rem = {lane_i.rem[ByteW-2:0], lane_i.aq[ByteW-1]};
      lane_d.aq  = {lane_i.aq[ByteW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= lane_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      lane_q <= lane_d;
    end
  end

  always_comb begin
    lane_o       = lane_q;
    lane_o.valid = valid_q;
  end

endmodule

>>> hdl/x86_decimal_adjust_unit.sv
// Top level of the x86 decimal and ASCII adjust unit.
// Each request passes through the eight registered cells of the chain, one cell per AAM quotient bit.
// Throughput: one request per cycle unless a waiting result stalls it; the whole eight-cell chain advances together.
// The last cell doubles as the output register, so a waiting result stalls the chain.
// Reset clears the valid bits of every cell; the payload registers are not reset.
module x86_decimal_adjust_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  dau_pkg::dau_req_t in_req_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output dau_pkg::dau_res_t out_res_o
);
  import dau_pkg::*;
  `include "x86_decimal_adjust_unit_macros.svh"

  dau_lane_t lane [DivSteps+1];
  logic      adv;
  dau_lane_t last;

  assign adv        = !lane[DivSteps].valid || !out_stall_i;
  assign in_stall_o = !adv;

  dau_adjust u_adjust (
    .req_i   (in_req_i),
    .valid_i (in_valid_i),
    .lane_o  (lane[0])
  );

  for (genvar k = 0; k < DivSteps; k++) begin : g_cell
    dau_div_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (adv),
      .lane_i (lane[k]),
      .lane_o (lane[k+1])
    );
  end

  assign last = lane[DivSteps];

  always_comb begin
    out_res_o = last.res;
    if (last.do_div) begin
      out_res_o.al_out = last.rem;
      out_res_o.ah_out = last.aq;
      {out_res_o.pf_out, out_res_o.sf_out, out_res_o.zf_out} = dau_zsp(last.rem);
    end
  end

  assign out_valid_o = last.valid;

  // The input only stalls behind a result that is itself held up.
  `DAU_ASSERT_IMPL(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)
  // A finished division always leaves a remainder below the base.
  `DAU_ASSERT_IMPL(a_rem_below_base, clk_i, rst_ni, last.valid && last.do_div,
                   last.rem < last.div)
  // While the chain is frozen, the first and middle cells neither gain nor lose a request.
  `DAU_ASSERT_NEXT(a_chain_frozen, clk_i, rst_ni, !adv,
                   $stable(lane[1].valid) && $stable(lane[DivSteps/2].valid))

endmodule
